>>> design/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PUT,
        S_POP,
        S_DONE
    } t_state;

endpackage

>>> design/spq_if.sv
`timescale 1ns / 1ps

interface spq_req_if import spq_pkg::*; #(
    parameter int PRIO_W = 8,
    parameter int PAY_W  = 16
);
    logic              valid;
    logic              ready;
    t_op               operation;
    logic [PRIO_W-1:0] priority_req;
    logic [PAY_W-1:0]  payload;

    modport source (output valid, output operation, output priority_req, output payload,
                    input ready);
    modport sink   (input valid, input operation, input priority_req, input payload,
                    output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; #(
    parameter int PRIO_W = 8,
    parameter int PAY_W  = 16,
    parameter int CNT_W  = 5
);
    logic              valid;
    logic              ready;
    t_status           status;
    logic [PRIO_W-1:0] out_priority;
    logic [PAY_W-1:0]  out_payload;
    logic              is_empty;
    logic [CNT_W-1:0]  occupancy;

    modport source (output valid, output status, output out_priority, output out_payload,
                    output is_empty, output occupancy, input ready);
    modport sink   (input valid, input status, input out_priority, input out_payload,
                    input is_empty, input occupancy, output ready);
endinterface

>>> design/spq_ram.sv
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/stable_priority_queue.sv
`timescale 1ns / 1ps
// Insert: each entry of higher priority number is moved back one slot, one per cycle through
//   the single comparator and the RAM's read and write ports, before the new entry is written.
// Remove: one RAM read of the head. Dropped insert or empty remove goes straight to completion.
// A new request is accepted the cycle after the result is formed; the result register
//   holds it while the next request runs. One request at a time; a full output register stalls.
// Reset (synchronous, active low) empties the queue; slot RAM is not cleared.
module stable_priority_queue import spq_pkg::*; #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;
    localparam logic [IW:0] LIM = (IW + 1)'(DEPTH);

    function automatic logic [IW-1:0] f_phys(input logic [IW-1:0] base,
                                             input logic [IW-1:0] ofs);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= LIM) begin
            sum = sum - LIM;
        end
        return sum[IW-1:0];
    endfunction

    t_state                   r_state, n_state;
    logic [IW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic [IW-1:0]            r_idx, n_idx;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;
    logic [PAYLOAD_BITS-1:0]  r_pay, n_pay;
    t_status                  r_status, n_status;
    logic [PRIORITY_BITS-1:0] r_res_prio, n_res_prio;
    logic [PAYLOAD_BITS-1:0]  r_res_pay, n_res_pay;
    logic                     r_out_valid, n_out_valid;
    t_status                  r_o_status, n_o_status;
    logic [PRIORITY_BITS-1:0] r_o_prio, n_o_prio;
    logic [PAYLOAD_BITS-1:0]  r_o_pay, n_o_pay;
    logic                     r_o_empty, n_o_empty;
    logic [CW-1:0]            r_o_count, n_o_count;

    logic                     req_acc;
    logic                     out_free;
    logic                     is_full;
    logic                     greater;
    logic                     ram_we;
    logic [IW-1:0]            ram_waddr;
    logic [EW-1:0]            ram_wdata;
    logic [IW-1:0]            ram_raddr;
    logic [EW-1:0]            ram_rdata;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [PAYLOAD_BITS-1:0]  rd_pay;

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_prio  = ram_rdata[EW-1:PAYLOAD_BITS];
    assign rd_pay   = ram_rdata[PAYLOAD_BITS-1:0];
    assign greater  = rd_prio > r_prio;
    assign is_full  = r_count == CW'(DEPTH);
    assign req_acc  = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready        = r_state == S_IDLE;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.out_priority = r_o_prio;
    assign o_rsp.out_payload  = r_o_pay;
    assign o_rsp.is_empty     = r_o_empty;
    assign o_rsp.occupancy    = r_o_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.operation == OP_INSERT) begin
                        if (is_full) begin
                            n_state = S_DONE;
                        end else if (r_count == '0) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_POP;
                    end
                end
            end
            S_SCAN: begin
                if (!greater) begin
                    n_state = S_DONE;
                end else if (r_idx == IW'(1)) begin
                    n_state = S_PUT;
                end
            end
            S_PUT:  n_state = S_DONE;
            S_POP:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_prio      = r_prio;
        n_pay       = r_pay;
        n_status    = r_status;
        n_res_prio  = r_res_prio;
        n_res_pay   = r_res_pay;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_o_status  = r_o_status;
        n_o_prio    = r_o_prio;
        n_o_pay     = r_o_pay;
        n_o_empty   = r_o_empty;
        n_o_count   = r_o_count;
        ram_we      = 1'b0;
        ram_waddr   = f_phys(r_head, r_idx);
        ram_wdata   = {r_prio, r_pay};
        ram_raddr   = f_phys(r_head, r_idx - IW'(1));
        case (r_state)
            S_IDLE: begin
                if (i_req.operation == OP_REMOVE) begin
                    ram_raddr = r_head;
                end else begin
                    ram_raddr = f_phys(r_head, r_count[IW-1:0] - IW'(1));
                end
                if (req_acc) begin
                    n_prio     = i_req.priority_req;
                    n_pay      = i_req.payload;
                    n_idx      = r_count[IW-1:0];
                    n_res_prio = '0;
                    n_res_pay  = '0;
                    n_status   = ST_DONE;
                    if (i_req.operation == OP_INSERT && is_full) begin
                        n_status = ST_FULL;
                    end else if (i_req.operation == OP_REMOVE && r_count == '0) begin
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_SCAN: begin
                ram_we = 1'b1;
                if (greater) begin
                    // move the later entry back one slot, fetch the one ahead of it
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - IW'(1);
                    ram_raddr = f_phys(r_head, r_idx - IW'(2));
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            S_PUT: begin
                ram_we  = 1'b1;
                n_count = r_count + CW'(1);
            end
            S_POP: begin
                n_res_prio = rd_prio;
                n_res_pay  = rd_pay;
                n_head     = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + IW'(1);
                n_count    = r_count - CW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_prio    = r_res_prio;
                    n_o_pay     = r_res_pay;
                    n_o_empty   = r_count == '0;
                    n_o_count   = r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_prio     <= n_prio;
        r_pay      <= n_pay;
        r_status   <= n_status;
        r_res_prio <= n_res_prio;
        r_res_pay  <= n_res_pay;
        r_o_status <= n_o_status;
        r_o_prio   <= n_o_prio;
        r_o_pay    <= n_o_pay;
        r_o_empty  <= n_o_empty;
        r_o_count  <= n_o_count;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_count_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |=> $stable(r_count))
        else $error("occupancy changed while idle");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_req.operation == OP_REMOVE && r_count == '0
        |=> r_state == S_DONE && r_status == ST_EMPTY)
        else $error("remove on empty queue not flagged");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_idx != '0)
        else $error("scan past head slot");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside completion");

endmodule
